@@ rtl/core/i2p_pkg.sv @@
// Shared types and constants of the infix-to-postfix converter.
`default_nettype none
package i2p_pkg;

	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_expression;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_symbol;
		logic       last;
		logic       error;
	} out_item_t;

	localparam logic [7:0] CH_OPEN  = 8'h28; // (
	localparam logic [7:0] CH_CLOSE = 8'h29; // )
	localparam logic [7:0] CH_MUL   = 8'h2A; // *
	localparam logic [7:0] CH_ADD   = 8'h2B; // +
	localparam logic [7:0] CH_SUB   = 8'h2D; // -
	localparam logic [7:0] CH_DIV   = 8'h2F; // /
	localparam logic [7:0] CH_MOD   = 8'h25; // %
	localparam logic [7:0] CH_NONE  = 8'h00;

	localparam logic [2:0] KIND_OPERAND  = 3'd0;
	localparam logic [2:0] KIND_OPERATOR = 3'd1;
	localparam logic [2:0] KIND_OPEN     = 3'd2;
	localparam logic [2:0] KIND_CLOSE    = 3'd3;
	localparam logic [2:0] KIND_END      = 3'd4;

	// precedence: 2 for * / %, 1 for + -, 0 for everything else
	function automatic logic [1:0] op_rank(input logic [7:0] c);
		logic [1:0] r;
		r = 2'd0;
		if (c == CH_MUL || c == CH_DIV || c == CH_MOD) begin
			r = 2'd2;
		end else if (c == CH_ADD || c == CH_SUB) begin
			r = 2'd1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/infix_to_postfix_converter.sv @@
// Shunting-yard infix-to-postfix converter with a memory-based operator stack.
// One character enters per transaction; operands come out again, operators wait on a
// stack of STACK_DEPTH entries held in a synchronous RAM, and the top entry is cached in
// a register. For each popped operator, the operator is emitted while the entry below
// is read from the RAM, and then the RAM read lands in the top register. An end
// transaction flushes the stack and sends a terminator with last set. When an input
// causes an error (overflow, unmatched '(' at the end, unmatched ')'), every result it
// produces carries error, and if it would produce none it sends one marker with
// symbol 0. A full result register stalls the work until it is taken.
`default_nettype none
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      item_valid,
	output logic                     item_ready,
	input  wire  i2p_pkg::in_item_t  item,
	output logic                     result_valid,
	input  wire                      result_ready,
	output i2p_pkg::out_item_t       result
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_LOAD = 2'd2;

	logic [7:0]    stack_mem [STACK_DEPTH];
	logic [7:0]    rd_data_q;
	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] open_q;
	logic [7:0]    top_q;
	logic [7:0]    sym_q;
	logic [2:0]    kind_q;
	logic          err_q;
	logic          emitted_q;
	logic          done_q;
	i2p_pkg::out_item_t out_q;
	logic          out_valid_q;

	logic [2:0]    in_kind;
	logic          in_err;
	logic          top_pops_in;
	logic          slot_free;
	logic          pop;
	logic          discard;
	logic          push;
	logic          finish;
	logic          emit_req;
	logic          stall;
	i2p_pkg::out_item_t emit_item;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] cnt_dec;

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign slot_free    = !out_valid_q || result_ready;
	assign cnt_dec      = cnt_q - CW'(1);
	assign rd_addr      = AW'(cnt_q - CW'(2));

	// classify the incoming character and decide its error flag up front
	always_comb begin
		in_kind = i2p_pkg::KIND_OPERAND;
		if (item.end_of_expression) begin
			in_kind = i2p_pkg::KIND_END;
		end else if (i2p_pkg::op_rank(item.symbol) != 2'd0) begin
			in_kind = i2p_pkg::KIND_OPERATOR;
		end else if (item.symbol == i2p_pkg::CH_OPEN) begin
			in_kind = i2p_pkg::KIND_OPEN;
		end else if (item.symbol == i2p_pkg::CH_CLOSE) begin
			in_kind = i2p_pkg::KIND_CLOSE;
		end
		// a full stack only overflows if the operator pops nothing first
		top_pops_in = (top_q != i2p_pkg::CH_OPEN) &&
			(i2p_pkg::op_rank(top_q) >= i2p_pkg::op_rank(item.symbol));
		case (in_kind)
			i2p_pkg::KIND_END:      in_err = (open_q != '0);
			i2p_pkg::KIND_CLOSE:    in_err = (open_q == '0);
			i2p_pkg::KIND_OPEN:     in_err = (cnt_q == FULL);
			i2p_pkg::KIND_OPERATOR: in_err = (cnt_q == FULL) && !top_pops_in;
			default:                in_err = 1'b0;
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		discard   = 1'b0;
		push      = 1'b0;
		finish    = 1'b0;
		emit_req  = 1'b0;
		emit_item = '{out_symbol: i2p_pkg::CH_NONE, last: 1'b0, error: err_q};
		if (state_q == ST_RUN) begin
			if (done_q) begin
				finish = 1'b1;
			end else if (cnt_q != '0 && (kind_q == i2p_pkg::KIND_END ||
					kind_q == i2p_pkg::KIND_CLOSE ||
					(kind_q == i2p_pkg::KIND_OPERATOR && top_q != i2p_pkg::CH_OPEN &&
					i2p_pkg::op_rank(top_q) >= i2p_pkg::op_rank(sym_q)))) begin
				pop     = 1'b1;
				discard = (top_q == i2p_pkg::CH_OPEN);
				if (!discard) begin
					emit_req             = 1'b1;
					emit_item.out_symbol = top_q;
				end
			end else begin
				finish = 1'b1;
				case (kind_q)
					i2p_pkg::KIND_OPERAND: begin
						emit_req             = 1'b1;
						emit_item.out_symbol = sym_q;
					end
					i2p_pkg::KIND_OPERATOR, i2p_pkg::KIND_OPEN: begin
						if (cnt_q != FULL) begin
							push = 1'b1;
						end else begin
							emit_req = !emitted_q;
						end
					end
					i2p_pkg::KIND_CLOSE: begin
						emit_req = err_q && !emitted_q;
					end
					i2p_pkg::KIND_END: begin
						emit_req       = 1'b1;
						emit_item.last = 1'b1;
					end
					default: begin
						finish = 1'b1;
					end
				endcase
			end
		end
		stall = emit_req && !slot_free;
	end

	// stack RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (push && !stall) begin
			stack_mem[AW'(cnt_q)] <= sym_q;
		end
		rd_data_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			open_q      <= '0;
			out_valid_q <= 1'b0;
			emitted_q   <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (emit_req && !stall) begin
				out_valid_q <= 1'b1;
				emitted_q   <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q   <= ST_RUN;
						emitted_q <= 1'b0;
						done_q    <= 1'b0;
					end
				end
				ST_RUN: begin
					if (!stall) begin
						if (pop) begin
							cnt_q   <= cnt_dec;
							state_q <= ST_LOAD;
							if (discard) begin
								open_q <= open_q - CW'(1);
								// matching '(' ends a ')' transaction
								if (kind_q == i2p_pkg::KIND_CLOSE) begin
									done_q <= 1'b1;
								end
							end
						end else if (finish) begin
							state_q <= ST_IDLE;
							if (push) begin
								cnt_q <= cnt_q + CW'(1);
								if (kind_q == i2p_pkg::KIND_OPEN) begin
									open_q <= open_q + CW'(1);
								end
							end
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			sym_q  <= item.symbol;
			kind_q <= in_kind;
			err_q  <= in_err;
		end
		if (emit_req && !stall) begin
			out_q <= emit_item;
		end
		if (push && !stall) begin
			top_q <= sym_q;
		end else if (state_q == ST_LOAD) begin
			top_q <= rd_data_q;
		end
	end

endmodule
`default_nettype wire

@@ tb/i2p_checker.sv @@
// Checker for the infix-to-postfix converter: predicts postfix output and compares results.
`timescale 1ns / 100ps
module i2p_checker
	import i2p_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        item_valid,
	input  wire        item_ready,
	input  in_item_t   item,
	input  wire        result_valid,
	input  wire        result_ready,
	input  out_item_t  result,
	output int         fail_count,
	output int         pending
);

	logic [7:0] opstack [STACK_DEPTH];
	int         stack_count;
	out_item_t  expected_postfix [$];
	out_item_t  want;
	int         mismatches = 0;

	function automatic int precedence(input logic [7:0] c);
		case (c)
			CH_MUL, CH_DIV, CH_MOD: return 2;
			CH_ADD, CH_SUB:         return 1;
			default:                return 0;
		endcase
	endfunction

	// Shunting-yard step for one accepted transaction; queues every result it causes.
	task automatic convert_symbol(input in_item_t it);
		out_item_t  produced [$];
		logic [7:0] sym;
		logic       bad;
		logic       matched;
		sym = it.symbol;
		bad = 1'b0;
		if (it.end_of_expression) begin
			while (stack_count > 0) begin
				stack_count--;
				if (opstack[stack_count] == CH_OPEN) begin
					bad = 1'b1; // unmatched '(' is dropped and flags the results as errors
				end else begin
					produced.push_back({opstack[stack_count], 1'b0, 1'b0});
				end
			end
			produced.push_back({CH_NONE, 1'b1, 1'b0});
		end else if (precedence(sym) != 0 || sym == CH_OPEN) begin
			if (sym != CH_OPEN) begin
				while (stack_count > 0 && opstack[stack_count - 1] != CH_OPEN &&
				       precedence(opstack[stack_count - 1]) >= precedence(sym)) begin
					stack_count--;
					produced.push_back({opstack[stack_count], 1'b0, 1'b0});
				end
			end
			if (stack_count >= STACK_DEPTH) begin
				bad = 1'b1; // push onto a full stack is dropped
			end else begin
				opstack[stack_count] = sym;
				stack_count++;
			end
		end else if (sym == CH_CLOSE) begin
			matched = 1'b0;
			while (stack_count > 0 && !matched) begin
				stack_count--;
				if (opstack[stack_count] == CH_OPEN) begin
					matched = 1'b1;
				end else begin
					produced.push_back({opstack[stack_count], 1'b0, 1'b0});
				end
			end
			if (!matched) begin
				bad = 1'b1;
			end
		end else begin
			produced.push_back({sym, 1'b0, 1'b0});
		end
		if (bad) begin
			if (produced.size() == 0) begin
				produced.push_back({CH_NONE, 1'b0, 1'b0});
			end
			foreach (produced[i]) begin
				produced[i].error = 1'b1;
			end
		end
		foreach (produced[i]) begin
			expected_postfix.push_back(produced[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_count = 0;
			expected_postfix.delete();
			pending <= 0;
		end else begin
			if (item_valid && item_ready) begin
				convert_symbol(item);
			end
			if (result_valid && result_ready) begin
				if (expected_postfix.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: unexpected result sym=%h last=%b err=%b", $realtime,
							result.out_symbol, result.last, result.error);
					end
				end else begin
					want = expected_postfix.pop_front();
					if (result.out_symbol !== want.out_symbol || result.last !== want.last ||
					    result.error !== want.error) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch exp sym=%h last=%b err=%b, got sym=%h last=%b err=%b",
								$realtime, want.out_symbol, want.last, want.error,
								result.out_symbol, result.last, result.error);
						end
					end
				end
			end
			pending <= expected_postfix.size();
			fail_count <= mismatches;
		end
	end

endmodule

@@ tb/tb_infix_to_postfix_converter.sv @@
// Testbench top for the infix-to-postfix converter: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_infix_to_postfix_converter;
	import i2p_pkg::*;

	localparam int STACK_DEPTH    = 16;
	localparam int ITEM_TARGET    = 310;
	localparam int QUIET_FROM     = 270;
	localparam int HOLD_OFF_AT    = 120;
	localparam int HOLD_OFF_LEN   = 400;
	localparam int WATCHDOG_LIMIT = 3000;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_item_t  item;
	logic      result_valid;
	logic      result_ready;
	out_item_t result;
	int        fail_count;
	int        pending;

	int        sent = 0;
	int        tx_idle_pct = 0;
	int        rx_idle_pct = 0;
	bit        held_off = 1'b0;
	int        quiet_cycles;

	infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	i2p_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(0, 4))
			0:       return CH_MUL;
			1:       return CH_DIV;
			2:       return CH_MOD;
			3:       return CH_ADD;
			default: return CH_SUB;
		endcase
	endfunction

	function automatic logic [7:0] pick_operand();
		logic [7:0] b;
		if ($urandom_range(0, 1)) begin
			return 8'h61 + 8'($urandom_range(0, 25));
		end
		b = 8'($urandom_range(0, 255));
		while (b inside {CH_OPEN, CH_CLOSE, CH_MUL, CH_ADD, CH_SUB, CH_DIV, CH_MOD}) begin
			b = 8'($urandom_range(0, 255));
		end
		return b;
	endfunction

	// Offers one transaction and returns at the edge where it is taken.
	task automatic send_item(input logic [7:0] sym, input logic eoe);
		if (tx_idle_pct > 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{symbol: sym, end_of_expression: eoe};
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		sent++;
	endtask

	// Well-formed expression: operands and operators alternate, parentheses balanced.
	task automatic send_expression();
		int  terms;
		int  level;
		bit  want_operand;
		terms        = $urandom_range(1, 8);
		level        = 0;
		want_operand = 1'b1;
		while (want_operand || level > 0 || terms > 0) begin
			if (want_operand) begin
				if (level < 6 && $urandom_range(0, 3) == 0) begin
					send_item(CH_OPEN, 1'b0);
					level++;
				end else begin
					send_item(pick_operand(), 1'b0);
					want_operand = 1'b0;
					terms--;
				end
			end else if (level > 0 && (terms <= 0 || $urandom_range(0, 2) == 0)) begin
				send_item(CH_CLOSE, 1'b0);
				level--;
			end else if (terms > 0) begin
				send_item(pick_operator(), 1'b0);
				want_operand = 1'b1;
			end else begin
				break;
			end
		end
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Deep nesting to drive the stack toward and past full.
	task automatic send_deep_nesting(input int min_level);
		int target;
		int level;
		target = $urandom_range(min_level, 20);
		level  = 0;
		while (level < target) begin
			send_item(CH_OPEN, 1'b0);
			level++;
			if ($urandom_range(0, 1)) begin
				send_item(pick_operand(), 1'b0);
				send_item(pick_operator(), 1'b0);
				level++;
			end
		end
		repeat ($urandom_range(0, target)) begin
			send_item(pick_operand(), 1'b0);
			send_item(CH_CLOSE, 1'b0);
		end
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// Random junk; sometimes left without an end so the next expression inherits the stack.
	task automatic send_noise();
		repeat ($urandom_range(1, 10)) begin
			case ($urandom_range(0, 3))
				0:       send_item(pick_operator(), 1'b0);
				1:       send_item(CH_OPEN, 1'b0);
				2:       send_item(CH_CLOSE, 1'b0);
				default: send_item(8'($urandom_range(0, 255)), 1'b0);
			endcase
		end
		if ($urandom_range(0, 3) != 0) begin
			send_item(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	function automatic int pick_idle();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 15;
			default: return 40;
		endcase
	endfunction

	// receiver: random stall bursts plus one long hold-off to back the block up
	initial begin
		result_ready = 1'b0;
		forever begin
			if (!held_off && sent >= HOLD_OFF_AT) begin
				result_ready <= 1'b0;
				held_off = 1'b1;
				repeat (HOLD_OFF_LEN) @(posedge clk);
			end else if (rx_idle_pct > 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		string infix;
		int    expr_index;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every operator, parentheses, equal and higher precedence pops, flush at end
		infix = "a*(b+c)-d%e/f";
		foreach (infix[i]) begin
			send_item(infix[i], 1'b0);
		end
		send_item(CH_NONE, 1'b1);
		// close parenthesis on an empty stack: lone error marker
		send_item(CH_CLOSE, 1'b0);
		// close parenthesis with operators stacked but no open
		send_item("x", 1'b0);
		send_item(CH_ADD, 1'b0);
		send_item(CH_CLOSE, 1'b0);
		// open parentheses left at the end: terminator flagged
		send_item(CH_OPEN, 1'b0);
		send_item(CH_OPEN, 1'b0);
		send_item(8'h55, 1'b1);
		// operand extremes, caret as operand, end item with all symbol bits set
		send_item(8'h00, 1'b0);
		send_item("^", 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b1);

		expr_index = 0;
		while (sent < ITEM_TARGET) begin
			if (sent >= QUIET_FROM) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end else begin
				tx_idle_pct = pick_idle();
				rx_idle_pct = pick_idle();
			end
			if (expr_index == 0) begin
				send_deep_nesting(18);
			end else if (expr_index % 6 == 0) begin
				send_deep_nesting(12);
			end else if ($urandom_range(0, 4) == 0) begin
				send_noise();
			end else begin
				send_expression();
			end
			expr_index++;
		end
		item_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/i2p_pkg.sv
rtl/core/infix_to_postfix_converter.sv
tb/i2p_checker.sv
tb/tb_infix_to_postfix_converter.sv
